FILE: design/rcfr_pkg.sv
// ----------------------------------------------------------------------------
// Frame receiver package
// Widths, frame codes, decimal weights and the result status codes shared by
// the frame receiver interfaces and modules.
// ----------------------------------------------------------------------------
package rcfr_pkg;

    localparam int BYTE_W   = 8;
    localparam int PAIR_W   = 8;
    localparam int FREQ_W   = 32;
    localparam int STATUS_W = 2;

    // Number of BCD bytes that can contribute to a frequency.
    localparam int NUM_TERMS = 5;

    localparam logic [BYTE_W-1:0] END_MARK   = 8'hfd;
    localparam logic [BYTE_W-1:0] OK_CODE    = 8'hfb;
    localparam logic [BYTE_W-1:0] NG_CODE    = 8'hfa;
    localparam logic [BYTE_W-1:0] PREAMBLE   = 8'hfe;
    localparam logic [BYTE_W-1:0] ADDR_RESET = 8'he0;

    localparam logic [FREQ_W-1:0] W_1E8 = 32'd100000000;
    localparam logic [FREQ_W-1:0] W_1E6 = 32'd1000000;
    localparam logic [FREQ_W-1:0] W_1E4 = 32'd10000;
    localparam logic [FREQ_W-1:0] W_1E2 = 32'd100;
    localparam logic [FREQ_W-1:0] W_1E0 = 32'd1;
    localparam logic [FREQ_W-1:0] W_NONE = 32'd0;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_NONE = 2'd0,
        STATUS_OK   = 2'd1,
        STATUS_NG   = 2'd2,
        STATUS_FREQ = 2'd3
    } t_status;

endpackage

FILE: design/rcfr_in_if.sv
// ----------------------------------------------------------------------------
// Frame receiver input channel
// Valid/ready channel that carries one received serial byte per item.
// ----------------------------------------------------------------------------
interface rcfr_in_if import rcfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: design/rcfr_out_if.sv
// ----------------------------------------------------------------------------
// Frame receiver output channel
// Valid/ready channel that carries one decode result per item.
// ----------------------------------------------------------------------------
interface rcfr_out_if import rcfr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FREQ_W-1:0]   frequency;
    logic                is_subband;

    modport source (output valid, output status, output frequency, output is_subband,
                    input ready);
    modport sink (input valid, input status, input frequency, input is_subband,
                  output ready);
endinterface

FILE: design/rcfr_cell.sv
// ----------------------------------------------------------------------------
// Byte history cell
// Holds one byte of the receive history, passes it to the next cell on a
// shift and presents its value read as a two-digit BCD number.
// ----------------------------------------------------------------------------
module rcfr_cell import rcfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic [BYTE_W-1:0] i_byte,
    output logic [BYTE_W-1:0] o_byte,
    output logic [PAIR_W-1:0] o_pair
);

    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;

    always_comb begin
        n_byte = i_shift ? i_byte : r_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    // Nibbles above nine are weighted as they are, so the pair tops out at 165.
    assign o_byte = r_byte;
    assign o_pair = PAIR_W'(PAIR_W'(r_byte[7:4]) * PAIR_W'(10)) + PAIR_W'(r_byte[3:0]);

endmodule

FILE: design/remote_control_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// Remote-control frame receiver
// Decodes reply frames of a serial radio control bus, one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one received byte per item; o_out gives exactly one result
//   per byte, in order: status (0 nothing, 1 OK, 2 NG, 3 frequency), the
//   decoded frequency in hertz and the subband flag for the first frequency.
//   i_cfg_we/i_cfg_data write the controller address; write it only while
//   no item is in flight.
//   The byte history is a chain of cells that shift once per accepted byte.
//   Behind it a three-stage pipeline matches the frame, forms the weighted
//   BCD terms, adds them and loads the output register. Each result passes
//   from the cells through the B, C and D registers to o_out.
//   One byte is taken every cycle while o_out is not stalled. Each stage
//   moves up whenever the stage after it is empty or moving, so a result
//   waiting in the output register still lets up to three more bytes in
//   before i_in.ready drops. Reset clears the history to zeros, the subband
//   flag and all stages, and sets the controller address to 0xe0.
// ----------------------------------------------------------------------------
module remote_control_frame_receiver_core import rcfr_pkg::*; #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [BYTE_W-1:0] i_cfg_data,
    rcfr_in_if.sink           i_in,
    rcfr_out_if.source        o_out
);

    logic [BYTE_W-1:0] w_byte [HISTORY_DEPTH];
    logic [PAIR_W-1:0] w_pair [HISTORY_DEPTH];

    logic w_accept;
    logic w_adv_a;
    logic w_adv_b;
    logic w_adv_c;
    logic w_adv_d;

    logic [BYTE_W-1:0] r_ctrl_addr;

    logic r_a_valid;
    logic r_b_valid;
    logic r_c_valid;
    logic r_d_valid;

    t_status           r_b_kind;
    t_status           n_b_kind;
    logic [FREQ_W-1:0] r_b_term [NUM_TERMS];
    logic [FREQ_W-1:0] n_b_term [NUM_TERMS];
    logic [FREQ_W-1:0] w_weight [NUM_TERMS];

    t_status           r_c_kind;
    logic [FREQ_W-1:0] r_c_sum_lo;
    logic [FREQ_W-1:0] r_c_sum_hi;

    logic [FREQ_W-1:0] w_sum;
    t_status           n_d_status;
    logic [FREQ_W-1:0] n_d_freq;
    logic              n_d_sub;
    t_status           r_d_status;
    logic [FREQ_W-1:0] r_d_freq;
    logic              r_d_sub;
    logic              r_subband_seen;

    logic w_ok;
    logic w_ng;
    logic w_f5;
    logic w_f4;

    // Handshake: a stage moves when it is empty or the next one moves.
    assign w_adv_d    = !r_d_valid || o_out.ready;
    assign w_adv_c    = !r_c_valid || w_adv_d;
    assign w_adv_b    = !r_b_valid || w_adv_c;
    assign w_adv_a    = !r_a_valid || w_adv_b;
    assign i_in.ready = w_adv_a;
    assign w_accept   = i_in.valid && w_adv_a;

    generate
        for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_hist
            if (g == 0) begin : g_head
                rcfr_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_accept),
                    .i_byte  (i_in.rx_byte),
                    .o_byte  (w_byte[g]),
                    .o_pair  (w_pair[g])
                );
            end else begin : g_body
                rcfr_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_accept),
                    .i_byte  (w_byte[g-1]),
                    .o_byte  (w_byte[g]),
                    .o_pair  (w_pair[g])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_addr <= ADDR_RESET;
        end else if (i_cfg_we) begin
            r_ctrl_addr <= i_cfg_data;
        end
    end

    // Stage A: the cells hold the history including the newest byte.
    always_comb begin
        w_ok = w_byte[0] == END_MARK && w_byte[1] == OK_CODE && w_byte[3] == r_ctrl_addr &&
               w_byte[4] == PREAMBLE && w_byte[5] == PREAMBLE;
        w_ng = w_byte[0] == END_MARK && w_byte[1] == NG_CODE && w_byte[3] == r_ctrl_addr &&
               w_byte[4] == PREAMBLE && w_byte[5] == PREAMBLE;
        w_f5 = w_byte[0] == END_MARK && w_byte[8] == r_ctrl_addr &&
               w_byte[9] == PREAMBLE && w_byte[10] == PREAMBLE;
        w_f4 = w_byte[0] == END_MARK && w_byte[7] == r_ctrl_addr &&
               w_byte[8] == PREAMBLE && w_byte[9] == PREAMBLE;

        w_weight[0] = W_NONE;
        w_weight[1] = W_NONE;
        w_weight[2] = W_NONE;
        w_weight[3] = W_NONE;
        w_weight[4] = W_NONE;
        n_b_kind    = STATUS_NONE;
        priority if (w_ok) begin
            n_b_kind = STATUS_OK;
        end else if (w_ng) begin
            n_b_kind = STATUS_NG;
        end else if (w_f5) begin
            n_b_kind    = STATUS_FREQ;
            w_weight[0] = W_1E8;
            w_weight[1] = W_1E6;
            w_weight[2] = W_1E4;
            w_weight[3] = W_1E2;
            w_weight[4] = W_1E0;
        end else if (w_f4) begin
            n_b_kind    = STATUS_FREQ;
            w_weight[0] = W_1E6;
            w_weight[1] = W_1E4;
            w_weight[2] = W_1E2;
            w_weight[3] = W_1E0;
        end else begin
            n_b_kind = STATUS_NONE;
        end

        // Byte k+1 of the history is the k-th term; the product wraps at 32 bits.
        for (int k = 0; k < NUM_TERMS; k++) begin
            n_b_term[k] = FREQ_W'(FREQ_W'(w_pair[k+1]) * w_weight[k]);
        end
    end

    // Stage D: final add and the result.
    always_comb begin
        w_sum      = r_c_sum_lo + r_c_sum_hi;
        n_d_status = r_c_kind;
        n_d_freq   = '0;
        n_d_sub    = 1'b0;
        if (r_c_kind == STATUS_FREQ) begin
            if (w_sum != '0) begin
                n_d_freq = w_sum;
                n_d_sub  = !r_subband_seen;
            end else begin
                n_d_status = STATUS_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid      <= 1'b0;
            r_b_valid      <= 1'b0;
            r_c_valid      <= 1'b0;
            r_d_valid      <= 1'b0;
            r_subband_seen <= 1'b0;
        end else begin
            if (w_adv_a) begin
                r_a_valid <= w_accept;
            end
            if (w_adv_b) begin
                r_b_valid <= r_a_valid;
            end
            if (w_adv_c) begin
                r_c_valid <= r_b_valid;
            end
            if (w_adv_d) begin
                r_d_valid <= r_c_valid;
                if (r_c_valid && n_d_status == STATUS_FREQ) begin
                    r_subband_seen <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_b) begin
            r_b_kind <= n_b_kind;
            r_b_term <= n_b_term;
        end
        if (w_adv_c) begin
            r_c_kind   <= r_b_kind;
            r_c_sum_lo <= r_b_term[0] + r_b_term[1] + r_b_term[2];
            r_c_sum_hi <= r_b_term[3] + r_b_term[4];
        end
        if (w_adv_d) begin
            r_d_status <= n_d_status;
            r_d_freq   <= n_d_freq;
            r_d_sub    <= n_d_sub;
        end
    end

    assign o_out.valid      = r_d_valid;
    assign o_out.status     = r_d_status;
    assign o_out.frequency  = r_d_freq;
    assign o_out.is_subband = r_d_sub;

    // The subband flag goes out only once the seen bit has been set with it.
    a_sub_marks_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.is_subband |-> r_subband_seen)
        else $error("subband flag shown without the seen bit set");

    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_subband_seen))
        else $error("subband seen bit cleared outside reset");

    a_head_cell_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_a_valid && w_byte[0] == $past(i_in.rx_byte))
        else $error("accepted byte did not enter the history");

    a_freq_only_with_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != STATUS_FREQ |-> o_out.frequency == '0 &&
        !o_out.is_subband)
        else $error("frequency fields set without a frequency status");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_b_valid && r_c_valid && r_d_valid && !o_out.ready |-> !i_in.ready)
        else $error("input ready while the pipeline is full and stalled");

endmodule
